[rtl/rc4_keystream_generator_macros.svh]
// ---------------------------------------------------------------------------
// RC4 keystream generator assertion macros
// Concurrent checks clocked on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RC4_KEYSTREAM_GENERATOR_MACROS_SVH
`define RC4_KEYSTREAM_GENERATOR_MACROS_SVH

// same-cycle implication
`define RC4KG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RC4KG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rc4kg_pkg.sv]
// ---------------------------------------------------------------------------
// rc4kg_pkg
// Shared types and constants of the RC4 keystream generator.
// ---------------------------------------------------------------------------
package rc4kg_pkg;

    localparam int KEY_BYTES_MAX_DEF = 256;
    localparam int PERM_AW           = 8;
    localparam int BYTE_W            = 8;
    localparam int COUNT_W           = 32;
    localparam int OUT_DATA_W        = BYTE_W + COUNT_W;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 32'd4000000000;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_GEN   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_K0, S_K1, S_K2, S_K3,
        S_G0, S_G1, S_G2, S_G3, S_G4, S_G5
    } t_state;

    typedef enum logic [2:0] {
        ADDR_N,
        ADDR_ACC_NEW,
        ADDR_ACC,
        ADDR_I_NEXT,
        ADDR_I,
        ADDR_J_NEXT,
        ADDR_J,
        ADDR_SUM
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_N,
        WD_RD,
        WD_A
    } t_wd_sel;

    typedef struct packed {
        logic      key_wr;
        logic      clear;
        logic      sched_start;
        logic      sched_done;
        logic      n_step;
        logic      pos_step;
        logic      acc_upd;
        logic      ld_a;
        logic      ld_b;
        logic      i_upd;
        logic      j_upd;
        logic      cnt_upd;
        logic      mem_rd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic n_last;
        logic out_free;
    } t_stat;

endpackage

[rtl/rc4kg_ctrl.sv]
// ---------------------------------------------------------------------------
// rc4kg_ctrl
// Sequencer: key load, key schedule, keystream step and clear.
// ---------------------------------------------------------------------------
module rc4kg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_kind,
    input  logic             i_last,
    input  rc4kg_pkg::t_stat i_stat,
    output logic             o_ready,
    output rc4kg_pkg::t_cmd  o_cmd
);

    rc4kg_pkg::t_state r_state;
    rc4kg_pkg::t_state n_state;
    logic              w_take;

    assign w_take = i_valid && (r_state == rc4kg_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rc4kg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rc4kg_pkg::S_IDLE: begin
                if (w_take) begin
                    priority case (i_kind)
                        rc4kg_pkg::KIND_LOAD: begin
                            if (i_last) begin
                                n_state = rc4kg_pkg::S_INIT;
                            end
                        end
                        rc4kg_pkg::KIND_GEN: n_state = rc4kg_pkg::S_G0;
                        default:             n_state = rc4kg_pkg::S_IDLE;
                    endcase
                end
            end
            rc4kg_pkg::S_INIT: begin
                if (i_stat.n_last) begin
                    n_state = rc4kg_pkg::S_K0;
                end
            end
            rc4kg_pkg::S_K0: n_state = rc4kg_pkg::S_K1;
            rc4kg_pkg::S_K1: n_state = rc4kg_pkg::S_K2;
            rc4kg_pkg::S_K2: n_state = rc4kg_pkg::S_K3;
            rc4kg_pkg::S_K3: begin
                n_state = i_stat.n_last ? rc4kg_pkg::S_IDLE : rc4kg_pkg::S_K0;
            end
            rc4kg_pkg::S_G0: n_state = rc4kg_pkg::S_G1;
            rc4kg_pkg::S_G1: n_state = rc4kg_pkg::S_G2;
            rc4kg_pkg::S_G2: n_state = rc4kg_pkg::S_G3;
            rc4kg_pkg::S_G3: n_state = rc4kg_pkg::S_G4;
            rc4kg_pkg::S_G4: n_state = rc4kg_pkg::S_G5;
            rc4kg_pkg::S_G5: begin
                if (i_stat.out_free) begin
                    n_state = rc4kg_pkg::S_IDLE;
                end
            end
            default: n_state = rc4kg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = rc4kg_pkg::ADDR_N;
        o_cmd.wd_sel   = rc4kg_pkg::WD_N;
        o_ready        = (r_state == rc4kg_pkg::S_IDLE);
        unique case (r_state)
            rc4kg_pkg::S_IDLE: begin
                if (w_take) begin
                    priority case (i_kind)
                        rc4kg_pkg::KIND_LOAD: begin
                            o_cmd.key_wr      = 1'b1;
                            o_cmd.sched_start = i_last;
                        end
                        rc4kg_pkg::KIND_CLEAR: o_cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            rc4kg_pkg::S_INIT: begin
                // identity fill
                o_cmd.mem_wr = 1'b1;
                o_cmd.n_step = 1'b1;
            end
            rc4kg_pkg::S_K0: begin
                o_cmd.mem_rd = 1'b1;
            end
            rc4kg_pkg::S_K1: begin
                o_cmd.ld_a     = 1'b1;
                o_cmd.acc_upd  = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = rc4kg_pkg::ADDR_ACC_NEW;
            end
            rc4kg_pkg::S_K2: begin
                o_cmd.ld_b   = 1'b1;
                o_cmd.mem_wr = 1'b1;
                o_cmd.wd_sel = rc4kg_pkg::WD_RD;
            end
            rc4kg_pkg::S_K3: begin
                o_cmd.mem_wr     = 1'b1;
                o_cmd.addr_sel   = rc4kg_pkg::ADDR_ACC;
                o_cmd.wd_sel     = rc4kg_pkg::WD_A;
                o_cmd.n_step     = 1'b1;
                o_cmd.pos_step   = 1'b1;
                o_cmd.sched_done = i_stat.n_last;
            end
            rc4kg_pkg::S_G0: begin
                o_cmd.i_upd    = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = rc4kg_pkg::ADDR_I_NEXT;
            end
            rc4kg_pkg::S_G1: begin
                o_cmd.ld_a     = 1'b1;
                o_cmd.j_upd    = 1'b1;
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = rc4kg_pkg::ADDR_J_NEXT;
            end
            rc4kg_pkg::S_G2: begin
                o_cmd.ld_b     = 1'b1;
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = rc4kg_pkg::ADDR_I;
                o_cmd.wd_sel   = rc4kg_pkg::WD_RD;
            end
            rc4kg_pkg::S_G3: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = rc4kg_pkg::ADDR_J;
                o_cmd.wd_sel   = rc4kg_pkg::WD_A;
                o_cmd.cnt_upd  = 1'b1;
            end
            rc4kg_pkg::S_G4: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = rc4kg_pkg::ADDR_SUM;
            end
            rc4kg_pkg::S_G5: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

[rtl/rc4kg_datapath.sv]
// ---------------------------------------------------------------------------
// rc4kg_datapath
// Permutation memory with valid bits, key memory, indexes, counter, output.
// ---------------------------------------------------------------------------
`include "rc4_keystream_generator_macros.svh"

module rc4kg_datapath #(
    parameter int KEY_BYTES_MAX = rc4kg_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rc4kg_pkg::t_cmd                  i_cmd,
    input  logic [rc4kg_pkg::BYTE_W-1:0]     i_key_byte,
    input  logic                             i_out_ready,
    output rc4kg_pkg::t_stat                 o_stat,
    output logic                             o_out_valid,
    output logic [rc4kg_pkg::OUT_DATA_W-1:0] o_out_data
);

    localparam int PERM_DEPTH = 1 << rc4kg_pkg::PERM_AW;
    localparam int KIDX_W     = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int LEN_W      = $clog2(KEY_BYTES_MAX + 1);

    typedef logic [rc4kg_pkg::BYTE_W-1:0] t_byte;

    // permutation memory, single port
    t_byte                         r_perm [PERM_DEPTH];
    logic [PERM_DEPTH-1:0]         r_valid;
    t_byte                         r_rd_data;
    logic                          r_rd_val;
    // key memory
    t_byte                         r_key_mem [KEY_BYTES_MAX];
    t_byte                         r_key_q;
    logic [LEN_W-1:0]              r_klen;
    logic [KIDX_W-1:0]             r_pos;
    // schedule and output-stage registers
    logic [rc4kg_pkg::PERM_AW-1:0] r_n;
    t_byte                         r_acc;
    t_byte                         r_i;
    t_byte                         r_j;
    t_byte                         r_a;
    t_byte                         r_b;
    logic [rc4kg_pkg::COUNT_W-1:0] r_count;
    logic                          r_out_valid;
    logic [rc4kg_pkg::OUT_DATA_W-1:0] r_out_data;

    t_byte                         w_rd;
    t_byte                         w_acc_new;
    logic [rc4kg_pkg::PERM_AW-1:0] w_addr;
    t_byte                         w_wd;
    logic                          w_key_room;
    logic [LEN_W-1:0]              w_pos_inc;
    logic                          w_out_free;

    // entries not written since reset or clear read as zero
    assign w_rd       = r_rd_val ? r_rd_data : '0;
    assign w_acc_new  = t_byte'(r_acc + w_rd + r_key_q);
    assign w_key_room = (r_klen < LEN_W'(KEY_BYTES_MAX));
    assign w_pos_inc  = LEN_W'(r_pos) + LEN_W'(1);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.addr_sel)
            rc4kg_pkg::ADDR_N:       w_addr = r_n;
            rc4kg_pkg::ADDR_ACC_NEW: w_addr = w_acc_new;
            rc4kg_pkg::ADDR_ACC:     w_addr = r_acc;
            rc4kg_pkg::ADDR_I_NEXT:  w_addr = t_byte'(r_i + t_byte'(1));
            rc4kg_pkg::ADDR_I:       w_addr = r_i;
            rc4kg_pkg::ADDR_J_NEXT:  w_addr = t_byte'(r_j + w_rd);
            rc4kg_pkg::ADDR_J:       w_addr = r_j;
            rc4kg_pkg::ADDR_SUM:     w_addr = t_byte'(r_a + r_b);
            default:                 w_addr = r_n;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wd_sel)
            rc4kg_pkg::WD_N:  w_wd = r_n;
            rc4kg_pkg::WD_RD: w_wd = w_rd;
            rc4kg_pkg::WD_A:  w_wd = r_a;
            default:          w_wd = r_n;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_perm[w_addr] <= w_wd;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_perm[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr && w_key_room) begin
            r_key_mem[r_klen[KIDX_W-1:0]] <= i_key_byte;
        end
        r_key_q <= r_key_mem[r_pos];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sched_start) begin
            r_n   <= '0;
            r_acc <= '0;
            r_pos <= '0;
        end else begin
            if (i_cmd.n_step) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.acc_upd) begin
                r_acc <= w_acc_new;
            end
            if (i_cmd.pos_step) begin
                r_pos <= (w_pos_inc >= r_klen) ? '0 : w_pos_inc[KIDX_W-1:0];
            end
        end
        if (i_cmd.ld_a) begin
            r_a <= w_rd;
        end
        if (i_cmd.ld_b) begin
            r_b <= w_rd;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_count, w_rd};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_val    <= 1'b0;
            r_klen      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.mem_wr) begin
                r_valid[w_addr] <= 1'b1;
            end
            if (i_cmd.mem_rd) begin
                r_rd_val <= r_valid[w_addr];
            end

            if (i_cmd.sched_done) begin
                r_klen <= '0;
            end else if (i_cmd.key_wr && w_key_room) begin
                r_klen <= r_klen + 1'b1;
            end

            if (i_cmd.clear || i_cmd.sched_done) begin
                r_i     <= '0;
                r_j     <= '0;
                r_count <= '0;
            end else begin
                if (i_cmd.i_upd) begin
                    r_i <= r_i + 1'b1;
                end
                if (i_cmd.j_upd) begin
                    r_j <= t_byte'(r_j + w_rd);
                end
                if (i_cmd.cnt_upd) begin
                    r_count <= (r_count < rc4kg_pkg::COUNT_LIMIT - 1'b1)
                             ? r_count + 1'b1 : rc4kg_pkg::COUNT_LIMIT;
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.n_last   = (r_n == '1);
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

    `RC4KG_ASSERT_NOW(a_cnt_limit, 1'b1, r_count <= rc4kg_pkg::COUNT_LIMIT, "count past limit")
    `RC4KG_ASSERT_NOW(a_klen_max, 1'b1, r_klen <= LEN_W'(KEY_BYTES_MAX), "key length overflow")
    `RC4KG_ASSERT_NOW(a_out_ovr, i_cmd.out_load, !r_out_valid || i_out_ready, "result overwritten")
    `RC4KG_ASSERT_NEXT(a_clr_idx, i_cmd.clear, r_count == '0 && r_i == '0 && r_j == '0, "clear missed")

endmodule

[rtl/rc4_keystream_generator.sv]
// Generate: the i/j/sum reads and the swap share one memory port in S_G0 to S_G4; S_G5 loads the
//   output register once it is free, and no new beat is taken until the block is idle again.
// Key load: one byte per cycle. Final key byte: 256-entry identity fill, then 256 steps.
// Clear: the table valid bits drop at once.
// Reset (i_rst_n low, synchronous): table reads as zeros, indexes, count and key length zero.
// ---------------------------------------------------------------------------
// rc4_keystream_generator
// RC4 keystream generator: key load, key schedule, byte generation, clear.
// ---------------------------------------------------------------------------
//
// Input beat: s_axis_tuser = kind (0 load key byte, 1 generate, 2 clear,
// 3 ignored), s_axis_tdata = key byte, s_axis_tlast = final key byte.
// Output beat (generate only): keystream byte and saturating byte count.
//
// The controller sequences one item at a time; the datapath holds a
// 256 x 8 single-port permutation memory whose entries carry valid bits so
// that reset and clear make it read as zeros at once. The key schedule
// first writes the identity, then runs each step in S_K0 to S_K3: read S[n]
// and the key byte, read S[acc], write S[n], write S[acc]. A result waits in
// the output register while the next beat is accepted; a second result
// stalls until the first is taken.
module rc4_keystream_generator #(
    parameter int KEY_BYTES_MAX = rc4kg_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] key_byte
    input  logic                             s_axis_tlast,  // key_last
    input  logic [1:0]                       s_axis_tuser,  // [1:0] kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] keystream_byte, [39:8] bytes_given
    output logic [rc4kg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    rc4kg_pkg::t_cmd  w_cmd;
    rc4kg_pkg::t_stat w_stat;

    rc4kg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .i_stat  (w_stat),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd)
    );

    rc4kg_datapath #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key_byte  (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for rc4_keystream_generator: key loads, key schedule,
// keystream beats and clears are predicted in the bench and every output
// beat is compared field by field, under several idle and stall mixes.
// ---------------------------------------------------------------------------
module testbench;
    import rc4kg_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int KEY_MAX        = KEY_BYTES_MAX_DEF;
    // longest quiet stretch: one key schedule plus a long sender gap,
    // or the deliberate output hold; taken several times over
    localparam int WATCHDOG_LIMIT = 20000;
    // drain time after the last expected beat, above one key schedule
    localparam int TAIL_CYCLES    = 1400;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 100;

    // kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  ks;
    } t_ks_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] key_byte
    logic                  s_axis_tlast;   // key_last
    logic [1:0]            s_axis_tuser;   // [1:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [7:0] keystream_byte, [39:8] bytes_given

    // predicted block state
    logic [7:0]         sbox [256];
    logic [7:0]         key_mem [256];
    int unsigned        key_len;
    logic [7:0]         idx_i;
    logic [7:0]         idx_j;
    logic [COUNT_W-1:0] gen_count;

    t_ks_beat   ks_expected[$];
    t_idle_mode idle_mode;
    logic       hold_req;
    int         errors;
    int         items_sent;
    int         keys_scheduled;
    int         beats_checked;
    int         idle_cycles;

    rc4_keystream_generator #(
        .KEY_BYTES_MAX(KEY_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Keystream predictor
    // -----------------------------------------------------------------------

    // 256-step schedule, key used cyclically over the bytes held
    function automatic void run_key_schedule();
        int unsigned pos;
        logic [7:0]  acc;
        logic [7:0]  tmp;
        pos = 0;
        acc = 8'd0;
        for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
        for (int n = 0; n < 256; n++) begin
            acc     = acc + sbox[n] + key_mem[pos[7:0]];
            tmp     = sbox[n];
            sbox[n] = sbox[acc];
            sbox[acc] = tmp;
            pos++;
            if (pos >= key_len) pos = 0;
        end
        idx_i     = 8'd0;
        idx_j     = 8'd0;
        gen_count = '0;
        key_len   = 0;
        keys_scheduled++;
    endfunction

    // advance the predicted state by one accepted input beat
    function automatic void step_keystream(input logic [1:0] kind, input logic [7:0] data,
                                           input logic last);
        logic [7:0] a;
        logic [7:0] b;
        t_ks_beat   beat;
        case (kind)
            KIND_LOAD: begin
                // bytes past the store size are dropped; the final one still counts
                if (key_len < KEY_MAX) begin
                    key_mem[key_len[7:0]] = data;
                    key_len++;
                end
                if (last) run_key_schedule();
            end
            KIND_GEN: begin
                idx_i = idx_i + 8'd1;
                a     = sbox[idx_i];
                idx_j = idx_j + a;
                b     = sbox[idx_j];
                sbox[idx_i] = b;
                sbox[idx_j] = a;
                if (gen_count < COUNT_LIMIT - 1) gen_count = gen_count + 1;
                else gen_count = COUNT_LIMIT;
                beat.ks    = sbox[a + b];
                beat.count = gen_count;
                ks_expected.push_back(beat);
            end
            KIND_CLEAR: begin
                // partial key survives a clear
                for (int n = 0; n < 256; n++) sbox[n] = 8'd0;
                idx_i     = 8'd0;
                idx_j     = 8'd0;
                gen_count = '0;
            end
            default: ;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Input side: one beat per call, gaps before it per idle mode
    // -----------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] data,
                             input logic last);
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 7 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = data;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_keystream(kind, data, last);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic send_gens(input int n);
        repeat (n) send_beat(KIND_GEN, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // random key bytes; finish marks the last one as final
    task automatic send_key(input int len, input logic finish);
        for (int k = 0; k < len; k++)
            send_beat(KIND_LOAD, 8'($urandom_range(255)), finish && (k == len - 1));
    endtask

    // -----------------------------------------------------------------------
    // Output side: ready per idle mode, with an optional long hold
    // -----------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                case (idle_mode)
                    IDLE_RECV: m_axis_tready = ($urandom_range(99) >= 77);
                    IDLE_BOTH: m_axis_tready = ($urandom_range(99) >= 7);
                    default:   m_axis_tready = 1'b1;
                endcase
            end
        end
    end

    // compare each output beat against the oldest expectation; track quiet cycles
    always @(posedge i_clk) begin
        t_ks_beat want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (ks_expected.size() == 0) begin
                $display("%0t: unexpected beat, actual ks=%02h count=%0d", $time,
                         m_axis_tdata[7:0], m_axis_tdata[39:8]);
                errors++;
            end else begin
                want = ks_expected.pop_front();
                if (m_axis_tdata[7:0] !== want.ks) begin
                    $display("%0t: keystream_byte expected %02h actual %02h", $time,
                             want.ks, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[39:8] !== want.count) begin
                    $display("%0t: bytes_given expected %0d actual %0d", $time,
                             want.count, m_axis_tdata[39:8]);
                    errors++;
                end
                beats_checked++;
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog: too long without any beat moving on either side
    initial begin
        @(posedge i_clk);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // table reads as zeros before any key; unused kind leaves state alone
    task automatic test_unkeyed_zeros();
        send_gens(3);
        send_beat(KIND_UNUSED, 8'hff, 1'b1);
        send_gens(1);
    endtask

    // one-byte keys at both extremes, then a three-byte ASCII key
    task automatic test_short_keys();
        send_beat(KIND_LOAD, 8'h00, 1'b1);
        send_gens(2);
        send_beat(KIND_LOAD, 8'hff, 1'b1);
        send_gens(2);
        send_beat(KIND_LOAD, 8'h4b, 1'b0);
        send_beat(KIND_LOAD, 8'h65, 1'b0);
        send_beat(KIND_LOAD, 8'h79, 1'b1);
        send_gens(4);
    endtask

    // clear mid-load: stream goes to zeros, partial key bytes are kept
    task automatic test_clear_keeps_partial();
        send_beat(KIND_LOAD, 8'h01, 1'b0);
        send_beat(KIND_LOAD, 8'hfe, 1'b0);
        send_beat(KIND_CLEAR, 8'h00, 1'b0);
        send_gens(2);
        send_beat(KIND_LOAD, 8'h80, 1'b1);
        send_gens(3);
    endtask

    // key past the store size; final byte beyond the limit still schedules
    task automatic test_key_overflow();
        send_key(KEY_MAX + 4, 1'b1);
        send_gens(8);
    endtask

    // output held off for a long stretch while generate beats keep coming
    task automatic test_output_backpressure();
        idle_mode = IDLE_NONE;
        send_key(5, 1'b1);
        hold_req = 1'b1;
        send_gens(20);
    endtask

    // mostly keyed generate runs, with clears, partial keys and noise mixed in
    task automatic test_random_traffic(input t_idle_mode mode);
        int start;
        int r;
        idle_mode = mode;
        start     = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_key(($urandom_range(24) == 0) ? $urandom_range(17, KEY_MAX)
                                                   : $urandom_range(1, 16), 1'b1);
                send_gens($urandom_range(4, 24));
            end else if (r < 17) begin
                send_beat(KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
                send_gens($urandom_range(1, 4));
            end else if (r < 21) begin
                send_beat(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (r < 25) begin
                // unfinished key: a later load extends it
                send_key($urandom_range(1, 4), 1'b0);
            end else begin
                send_gens($urandom_range(1, 16));
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tlast   = 1'b0;
        s_axis_tuser   = KIND_LOAD;
        idle_mode      = IDLE_NONE;
        hold_req       = 1'b0;
        errors         = 0;
        items_sent     = 0;
        keys_scheduled = 0;
        beats_checked  = 0;
        idle_cycles    = 0;
        key_len        = 0;
        idx_i          = 8'd0;
        idx_j          = 8'd0;
        gen_count      = '0;
        for (int n = 0; n < 256; n++) begin
            sbox[n]    = 8'd0;
            key_mem[n] = 8'd0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unkeyed_zeros();
        test_short_keys();
        test_clear_keeps_partial();
        test_key_overflow();
        test_output_backpressure();
        test_random_traffic(IDLE_NONE);
        test_random_traffic(IDLE_SEND);
        test_random_traffic(IDLE_RECV);
        test_random_traffic(IDLE_BOTH);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        idle_mode     = IDLE_NONE;
        while (ks_expected.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ks_expected.size() != 0) begin
            $display("%0t: %0d keystream beats never arrived", $time, ks_expected.size());
            errors += ks_expected.size();
        end

        $display("Ran %0d input beats with %0d key schedules; %0d keystream beats checked.",
                 items_sent, keys_scheduled, beats_checked);
        $display("Mixes: no idle, sender idle, receiver stall, both, and one long output hold.");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[rc4_keystream_generator.f]
+incdir+rtl
rtl/rc4kg_pkg.sv
rtl/rc4kg_ctrl.sv
rtl/rc4kg_datapath.sv
rtl/rc4_keystream_generator.sv
tb/sv/testbench.sv
